[rtl/core/suc_pkg.sv]
package suc_pkg;

    localparam int MAX_SPHERES_DEF = 64;

    localparam int CENTER_W  = 28;
    localparam int RADIUS_W  = 26;
    localparam int RSQ_W     = 2 * RADIUS_W;
    localparam int SITE_W    = 12;
    localparam int SPACING_W = 16;
    localparam int POS_W     = 28;
    localparam int DIFF_W    = 29;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int OVL_W     = 6;
    localparam int SITE_NUM_W = 20;
    localparam int ENTRY_W   = 3 * CENTER_W + RSQ_W;

    localparam logic [OVL_W-1:0]      OVL_MAX      = 6'd63;
    localparam logic [SITE_NUM_W-1:0] SITE_NUM_MAX = 20'hFFFFF;
    localparam logic [SPACING_W-1:0]  SPACING_RST  = 16'd16384;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_SPACING_X = 2'd0;
    localparam logic [1:0] REG_SPACING_Y = 2'd1;
    localparam logic [1:0] REG_SPACING_Z = 2'd2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK
    } state_t;

endpackage

[rtl/core/suc_ram.sv]
module suc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/sphere_union_site_classifier_top.sv]
// Sphere-union site classifier. Items enter on start while busy is low; mode 0 clears the
// sphere table and the occupied-site counter, mode 1 appends a sphere, mode 2 tests a lattice
// site against every stored sphere. Each item gives exactly one result, shown for a single
// cycle with done high; there is no back-pressure, so the receiver must take it then. A clear,
// a rejected load or an unused mode finishes straight from idle, an accepted load passes
// through the load state, and a query walks the sphere memory at one entry per cycle and
// feeds each entry through the distance pipeline (difference, squares, sum, compare) behind
// its read port. The spacing registers sit at byte addresses 0, 4 and 8 of the APB port
// and should only be written while busy is low.
module sphere_union_site_classifier_top #(
    parameter int MAX_SPHERES = suc_pkg::MAX_SPHERES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [suc_pkg::CFG_AW-1:0]        paddr,
    input  logic [suc_pkg::CFG_DW-1:0]        pwdata,
    output logic [suc_pkg::CFG_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic signed [suc_pkg::CENTER_W-1:0] center_x,
    input  logic signed [suc_pkg::CENTER_W-1:0] center_y,
    input  logic signed [suc_pkg::CENTER_W-1:0] center_z,
    input  logic [suc_pkg::RADIUS_W-1:0]      radius,
    input  logic signed [suc_pkg::SITE_W-1:0] site_jx,
    input  logic signed [suc_pkg::SITE_W-1:0] site_jy,
    input  logic signed [suc_pkg::SITE_W-1:0] site_jz,
    output logic                              done,
    output logic                              occupied,
    output logic [suc_pkg::OVL_W-1:0]         overlap_count,
    output logic [suc_pkg::SITE_NUM_W-1:0]    site_number,
    output logic                              table_full
);

    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);
    localparam int HW = (CW > suc_pkg::OVL_W + 1) ? CW : suc_pkg::OVL_W + 1;
    localparam int CNW = suc_pkg::CENTER_W;
    localparam int EW = suc_pkg::ENTRY_W;

    // Configuration registers
    logic [suc_pkg::SPACING_W-1:0] spacing_x_reg, spacing_y_reg, spacing_z_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_x_reg <= suc_pkg::SPACING_RST;
            spacing_y_reg <= suc_pkg::SPACING_RST;
            spacing_z_reg <= suc_pkg::SPACING_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                suc_pkg::REG_SPACING_X: spacing_x_reg <= pwdata[suc_pkg::SPACING_W-1:0];
                suc_pkg::REG_SPACING_Y: spacing_y_reg <= pwdata[suc_pkg::SPACING_W-1:0];
                suc_pkg::REG_SPACING_Z: spacing_z_reg <= pwdata[suc_pkg::SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            suc_pkg::REG_SPACING_X: prdata = {16'd0, spacing_x_reg};
            suc_pkg::REG_SPACING_Y: prdata = {16'd0, spacing_y_reg};
            suc_pkg::REG_SPACING_Z: prdata = {16'd0, spacing_z_reg};
            default:                prdata = '0;
        endcase
    end

    // Control state
    suc_pkg::state_t               state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [HW-1:0]                 hits_reg, hits_next;
    logic [suc_pkg::SITE_NUM_W-1:0] occ_cnt_reg, occ_cnt_next;
    logic                          v_rd_reg, v_d_reg, v_q_reg, v_s_reg;
    logic                          done_reg, done_next;
    logic                          occupied_reg, occupied_next;
    logic [suc_pkg::OVL_W-1:0]     overlap_reg, overlap_next;
    logic [suc_pkg::SITE_NUM_W-1:0] site_num_reg, site_num_next;
    logic                          full_reg, full_next;

    // Datapath registers
    logic signed [suc_pkg::POS_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [CNW-1:0]            ldx_reg, ldy_reg, ldz_reg;
    logic [suc_pkg::RSQ_W-1:0]        ldrsq_reg;
    logic signed [suc_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [suc_pkg::SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic [suc_pkg::SUM_W-1:0]        sum_reg;
    logic [suc_pkg::RSQ_W-1:0]        rsq_d_reg, rsq_q_reg, rsq_s_reg;

    logic          accept;
    logic          rd_en, wr_en, load_capture, query_capture;
    logic [EW-1:0] rd_data;
    logic [HW-1:0] hits_m1;
    logic          hit;
    logic          pipe_empty;

    assign accept = start && (state_reg == suc_pkg::ST_IDLE);
    assign busy   = (state_reg != suc_pkg::ST_IDLE);
    assign pipe_empty = !v_rd_reg && !v_d_reg && !v_q_reg && !v_s_reg;
    assign hit = v_s_reg && (sum_reg < {{(suc_pkg::SUM_W - suc_pkg::RSQ_W){1'b0}}, rsq_s_reg});
    assign hits_m1 = hits_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        hits_next     = hits_reg + {{(HW-1){1'b0}}, hit};
        occ_cnt_next  = occ_cnt_reg;
        done_next     = 1'b0;
        occupied_next = 1'b0;
        overlap_next  = '0;
        site_num_next = '0;
        full_next     = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        load_capture  = 1'b0;
        query_capture = 1'b0;
        unique case (state_reg)
            suc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        suc_pkg::MODE_CLEAR:
                        begin
                            count_next   = '0;
                            occ_cnt_next = '0;
                            done_next    = 1'b1;
                        end
                        suc_pkg::MODE_LOAD:
                        begin
                            if (count_reg >= CW'(MAX_SPHERES))
                            begin
                                full_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                load_capture = 1'b1;
                                state_next   = suc_pkg::ST_LOAD;
                            end
                        end
                        suc_pkg::MODE_QUERY:
                        begin
                            query_capture = 1'b1;
                            k_next        = '0;
                            hits_next     = '0;
                            state_next    = suc_pkg::ST_WALK;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            suc_pkg::ST_LOAD:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = suc_pkg::ST_IDLE;
            end
            suc_pkg::ST_WALK:
            begin
                if (k_reg < count_reg)
                begin
                    rd_en  = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                else if (pipe_empty)
                begin
                    // All compares have landed in the hit counter by now.
                    done_next  = 1'b1;
                    state_next = suc_pkg::ST_IDLE;
                    if (hits_reg != '0)
                    begin
                        occupied_next = 1'b1;
                        overlap_next  = (hits_m1 > HW'(suc_pkg::OVL_MAX)) ?
                                        suc_pkg::OVL_MAX : hits_m1[suc_pkg::OVL_W-1:0];
                        site_num_next = occ_cnt_reg;
                        if (occ_cnt_reg != suc_pkg::SITE_NUM_MAX)
                        begin
                            occ_cnt_next = occ_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = suc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= suc_pkg::ST_IDLE;
            count_reg    <= '0;
            k_reg        <= '0;
            hits_reg     <= '0;
            occ_cnt_reg  <= '0;
            v_rd_reg     <= 1'b0;
            v_d_reg      <= 1'b0;
            v_q_reg      <= 1'b0;
            v_s_reg      <= 1'b0;
            done_reg     <= 1'b0;
            occupied_reg <= 1'b0;
            overlap_reg  <= '0;
            site_num_reg <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            hits_reg     <= hits_next;
            occ_cnt_reg  <= occ_cnt_next;
            v_rd_reg     <= rd_en;
            v_d_reg      <= v_rd_reg;
            v_q_reg      <= v_d_reg;
            v_s_reg      <= v_q_reg;
            done_reg     <= done_next;
            occupied_reg <= occupied_next;
            overlap_reg  <= overlap_next;
            site_num_reg <= site_num_next;
            full_reg     <= full_next;
        end
    end

    // Capture of load and query operands; the square of the radius is formed on the way in.
    always_ff @(posedge clk)
    begin
        if (load_capture)
        begin
            ldx_reg   <= center_x;
            ldy_reg   <= center_y;
            ldz_reg   <= center_z;
            ldrsq_reg <= suc_pkg::RSQ_W'(radius) * suc_pkg::RSQ_W'(radius);
        end
        if (query_capture)
        begin
            px_reg <= suc_pkg::POS_W'(site_jx * $signed({1'b0, spacing_x_reg}));
            py_reg <= suc_pkg::POS_W'(site_jy * $signed({1'b0, spacing_y_reg}));
            pz_reg <= suc_pkg::POS_W'(site_jz * $signed({1'b0, spacing_z_reg}));
        end
    end

    suc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata ({ldrsq_reg, ldz_reg, ldy_reg, ldx_reg}),
        .re    (rd_en),
        .raddr (k_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // Distance pipeline: difference, squares, sum, then compare into the hit counter.
    logic signed [CNW-1:0] rcx, rcy, rcz;
    logic [suc_pkg::DIFF_W-1:0] ax, ay, az;

    assign rcx = rd_data[CNW-1:0];
    assign rcy = rd_data[2*CNW-1:CNW];
    assign rcz = rd_data[3*CNW-1:2*CNW];
    assign ax  = dx_reg[suc_pkg::DIFF_W-1] ? -dx_reg : dx_reg;
    assign ay  = dy_reg[suc_pkg::DIFF_W-1] ? -dy_reg : dy_reg;
    assign az  = dz_reg[suc_pkg::DIFF_W-1] ? -dz_reg : dz_reg;

    always_ff @(posedge clk)
    begin
        dx_reg    <= suc_pkg::DIFF_W'(px_reg) - suc_pkg::DIFF_W'(rcx);
        dy_reg    <= suc_pkg::DIFF_W'(py_reg) - suc_pkg::DIFF_W'(rcy);
        dz_reg    <= suc_pkg::DIFF_W'(pz_reg) - suc_pkg::DIFF_W'(rcz);
        rsq_d_reg <= rd_data[EW-1:3*CNW];
        sqx_reg   <= suc_pkg::SQ_W'(ax) * suc_pkg::SQ_W'(ax);
        sqy_reg   <= suc_pkg::SQ_W'(ay) * suc_pkg::SQ_W'(ay);
        sqz_reg   <= suc_pkg::SQ_W'(az) * suc_pkg::SQ_W'(az);
        rsq_q_reg <= rsq_d_reg;
        sum_reg   <= suc_pkg::SUM_W'(sqx_reg) + suc_pkg::SUM_W'(sqy_reg)
                   + suc_pkg::SUM_W'(sqz_reg);
        rsq_s_reg <= rsq_q_reg;
    end

    assign done          = done_reg;
    assign occupied      = occupied_reg;
    assign overlap_count = overlap_reg;
    assign site_number   = site_num_reg;
    assign table_full    = full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SPHERES))
        else $error("sphere count beyond table depth");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("table read and write in the same cycle");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (count_reg == CW'(MAX_SPHERES)))
        else $error("load rejected while the table had room");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !occupied) |-> (overlap_count == '0 && site_number == '0))
        else $error("unoccupied result carries overlap or site number");

    a_walk_ends_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == suc_pkg::ST_WALK && state_next == suc_pkg::ST_IDLE)
            |-> (pipe_empty && k_reg == count_reg))
        else $error("query finished with compares still in flight");

endmodule

[bench/suc_site_checker.sv]
module suc_site_checker
    import suc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [CFG_AW-1:0]           paddr,
    input  logic [CFG_DW-1:0]           pwdata,
    input  logic [CFG_DW-1:0]           prdata,
    input  logic                        pready,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  mode,
    input  logic signed [CENTER_W-1:0]  center_x,
    input  logic signed [CENTER_W-1:0]  center_y,
    input  logic signed [CENTER_W-1:0]  center_z,
    input  logic [RADIUS_W-1:0]         radius,
    input  logic signed [SITE_W-1:0]    site_jx,
    input  logic signed [SITE_W-1:0]    site_jy,
    input  logic signed [SITE_W-1:0]    site_jz,
    input  logic                        done,
    input  logic                        occupied,
    input  logic [OVL_W-1:0]            overlap_count,
    input  logic [SITE_NUM_W-1:0]       site_number,
    input  logic                        table_full,
    output int                          mismatches,
    output int                          pending
);

    typedef struct packed {
        logic                  occupied;
        logic [OVL_W-1:0]      overlap;
        logic [SITE_NUM_W-1:0] number;
        logic                  full;
    } site_result_t;

    logic [SPACING_W-1:0]  pitch [0:2];
    longint                ball_cx  [MAX_SPHERES_DEF];
    longint                ball_cy  [MAX_SPHERES_DEF];
    longint                ball_cz  [MAX_SPHERES_DEF];
    longint                ball_rsq [MAX_SPHERES_DEF];
    int                    balls_held;
    logic [SITE_NUM_W-1:0] next_site_number;
    site_result_t          expected_sites [$];
    int                    results_seen = 0;
    int                    fault_count = 0;

    assign mismatches = fault_count;

    task automatic report_mismatch(input string msg);
        fault_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic site_result_t classify_item(input logic [1:0] op);
        site_result_t res;
        longint       px, py, pz, dx, dy, dz;
        int           hits;
        res = '0;
        hits = 0;
        case (op)
            MODE_CLEAR:
            begin
                balls_held = 0;
                next_site_number = '0;
            end
            MODE_LOAD:
            begin
                if (balls_held >= MAX_SPHERES_DEF)
                    res.full = 1'b1;
                else
                begin
                    ball_cx[balls_held] = center_x;
                    ball_cy[balls_held] = center_y;
                    ball_cz[balls_held] = center_z;
                    ball_rsq[balls_held] = longint'(radius) * longint'(radius);
                    balls_held++;
                end
            end
            MODE_QUERY:
            begin
                px = longint'(site_jx) * longint'(pitch[REG_SPACING_X]);
                py = longint'(site_jy) * longint'(pitch[REG_SPACING_Y]);
                pz = longint'(site_jz) * longint'(pitch[REG_SPACING_Z]);
                for (int k = 0; k < balls_held; k++)
                begin
                    dx = px - ball_cx[k];
                    dy = py - ball_cy[k];
                    dz = pz - ball_cz[k];
                    // Strict inclusion: a site on the surface is outside.
                    if (dx * dx + dy * dy + dz * dz < ball_rsq[k])
                        hits++;
                end
                if (hits > 0)
                begin
                    res.occupied = 1'b1;
                    res.overlap = (hits - 1 > int'(OVL_MAX)) ? OVL_MAX : OVL_W'(hits - 1);
                    res.number = next_site_number;
                    if (next_site_number != SITE_NUM_MAX)
                        next_site_number++;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        site_result_t want;
        logic [1:0]   reg_idx;
        if (!rst_n)
        begin
            pitch[REG_SPACING_X] = SPACING_RST;
            pitch[REG_SPACING_Y] = SPACING_RST;
            pitch[REG_SPACING_Z] = SPACING_RST;
            balls_held = 0;
            next_site_number = '0;
            expected_sites.delete();
            pending <= 0;
        end
        else
        begin
            reg_idx = paddr[CFG_AW-1:2];
            if (start && !busy)
                expected_sites.insert(expected_sites.size(), classify_item(mode));

            if (done)
            begin
                results_seen++;
                if (expected_sites.size() == 0)
                    report_mismatch($sformatf("result %0d with no transaction outstanding",
                                              results_seen));
                else
                begin
                    want = expected_sites.pop_front();
                    if (occupied !== want.occupied)
                        report_mismatch($sformatf("result %0d: occupied %0b, expected %0b",
                                                  results_seen, occupied, want.occupied));
                    if (overlap_count !== want.overlap)
                        report_mismatch($sformatf("result %0d: overlap_count %0d, expected %0d",
                                                  results_seen, overlap_count, want.overlap));
                    if (site_number !== want.number)
                        report_mismatch($sformatf("result %0d: site_number %0d, expected %0d",
                                                  results_seen, site_number, want.number));
                    if (table_full !== want.full)
                        report_mismatch($sformatf("result %0d: table_full %0b, expected %0b",
                                                  results_seen, table_full, want.full));
                end
            end

            if (psel && penable && pready && reg_idx <= REG_SPACING_Z)
            begin
                if (pwrite)
                    pitch[reg_idx] = pwdata[SPACING_W-1:0];
                else if (prdata !== CFG_DW'(pitch[reg_idx]))
                    report_mismatch($sformatf("register %0d read %0h, expected %0h",
                                              reg_idx, prdata, pitch[reg_idx]));
            end

            pending <= expected_sites.size();
        end
    end

endmodule

[bench/tb.sv]
module tb;
    import suc_pkg::*;

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 125;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int ANCHORS        = 4;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int     ONE        = int'(SPACING_RST);
    localparam int     SPACING_HI = (1 << SPACING_W) - 1;
    localparam int     RADIUS_HI  = (1 << RADIUS_W) - 1;
    localparam int     SITE_HI    = (1 << (SITE_W - 1)) - 1;
    localparam int     SITE_LO    = -(1 << (SITE_W - 1));
    localparam longint CENTER_HI  = (longint'(1) << (CENTER_W - 1)) - 1;
    localparam longint CENTER_LO  = -(longint'(1) << (CENTER_W - 1));

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [CFG_AW-1:0]          paddr;
    logic [CFG_DW-1:0]          pwdata;
    logic [CFG_DW-1:0]          prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic [1:0]                 mode;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_z;
    logic [RADIUS_W-1:0]        radius;
    logic signed [SITE_W-1:0]   site_jx;
    logic signed [SITE_W-1:0]   site_jy;
    logic signed [SITE_W-1:0]   site_jz;
    logic                       done;
    logic                       occupied;
    logic [OVL_W-1:0]           overlap_count;
    logic [SITE_NUM_W-1:0]      site_number;
    logic                       table_full;
    int                         mismatches;
    int                         pending;

    int items_sent = 0;
    int burst_left = 0;
    int grid_x = ONE;
    int grid_y = ONE;
    int grid_z = ONE;
    int anchor_x [ANCHORS];
    int anchor_y [ANCHORS];
    int anchor_z [ANCHORS];

    sphere_union_site_classifier_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius        (radius),
        .site_jx       (site_jx),
        .site_jy       (site_jy),
        .site_jz       (site_jz),
        .done          (done),
        .occupied      (occupied),
        .overlap_count (overlap_count),
        .site_number   (site_number),
        .table_full    (table_full)
    );

    suc_site_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .center_x      (center_x),
        .center_y      (center_y),
        .center_z      (center_z),
        .radius        (radius),
        .site_jx       (site_jx),
        .site_jy       (site_jy),
        .site_jz       (site_jz),
        .done          (done),
        .occupied      (occupied),
        .overlap_count (overlap_count),
        .site_number   (site_number),
        .table_full    (table_full),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Any transaction on either port restarts the count.
    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (psel && penable && pready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input longint cx, input longint cy,
                             input longint cz, input int r, input int jx, input int jy,
                             input int jz);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        start    <= 1'b1;
        mode     <= op;
        center_x <= cx[CENTER_W-1:0];
        center_y <= cy[CENTER_W-1:0];
        center_z <= cz[CENTER_W-1:0];
        radius   <= r[RADIUS_W-1:0];
        site_jx  <= jx[SITE_W-1:0];
        site_jy  <= jy[SITE_W-1:0];
        site_jz  <= jz[SITE_W-1:0];
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    task automatic load_sphere(input longint cx, input longint cy, input longint cz,
                               input int r);
        send_item(MODE_LOAD, cx, cy, cz, r, $urandom, $urandom, $urandom);
    endtask

    task automatic query_site(input int jx, input int jy, input int jz);
        send_item(MODE_QUERY, $urandom, $urandom, $urandom, $urandom, jx, jy, jz);
    endtask

    task automatic clear_table();
        send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    endtask

    task automatic send_noise();
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(0, 7);
        op = (pick == 0) ? MODE_CLEAR : (pick < 4) ? MODE_LOAD
           : (pick < 7) ? MODE_QUERY : MODE_UNUSED;
        send_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0 || busy);
    endtask

    task automatic cfg_access(input logic [1:0] idx, input logic wr, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz);
        grid_x = sx;
        grid_y = sy;
        grid_z = sz;
        cfg_access(REG_SPACING_X, 1'b1, sx);
        cfg_access(REG_SPACING_Y, 1'b1, sy);
        cfg_access(REG_SPACING_Z, 1'b1, sz);
        cfg_access(REG_SPACING_X, 1'b0, 0);
        cfg_access(REG_SPACING_Y, 1'b0, 0);
        cfg_access(REG_SPACING_Z, 1'b0, 0);
    endtask

    function automatic int random_site_index();
        if ($urandom_range(0, 5) == 0)
            return int'($urandom_range(0, 4095)) + SITE_LO;
        return int'($urandom_range(0, 40)) - 20;
    endfunction

    function automatic int clamp_site(input int j);
        if (j > SITE_HI)
            return SITE_HI;
        if (j < SITE_LO)
            return SITE_LO;
        return j;
    endfunction

    // Centre on a lattice point, shifted by up to jitter in either direction.
    function automatic longint lattice_center(input int j, input int s, input int jitter);
        longint v;
        v = longint'(j) * s + longint'($urandom_range(0, 2 * jitter)) - jitter;
        if (v > CENTER_HI)
            return CENTER_HI;
        if (v < CENTER_LO)
            return CENTER_LO;
        return v;
    endfunction

    // A stacked cluster puts more spheres than the table holds around one site, so that
    // the overlap count reaches its ceiling and the last loads are turned away.
    task automatic run_sequence();
        int  nload, nquery, used, pick, s_min, s_max, rad, div;
        bit  stacked;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 6)) send_noise();
            return;
        end
        stacked = ($urandom_range(0, 4) == 0);
        if (stacked || $urandom_range(0, 3) != 0)
            clear_table();
        nload  = stacked ? MAX_SPHERES_DEF + 2 : $urandom_range(1, 12);
        nquery = stacked ? 4 : $urandom_range(2, 10);
        used   = stacked ? 1 : $urandom_range(1, ANCHORS);
        div    = stacked ? 2 : 1;
        s_max = grid_x;
        s_min = grid_x;
        if (grid_y > s_max) s_max = grid_y;
        if (grid_z > s_max) s_max = grid_z;
        if (grid_y < s_min) s_min = grid_y;
        if (grid_z < s_min) s_min = grid_z;
        for (int a = 0; a < used; a++)
        begin
            anchor_x[a] = random_site_index();
            anchor_y[a] = random_site_index();
            anchor_z[a] = random_site_index();
        end
        repeat (nload)
        begin
            pick = $urandom_range(0, used - 1);
            if (stacked)
                rad = s_max + $urandom_range(0, 2 * s_max);
            else if ($urandom_range(0, 5) == 0)
                rad = $urandom_range(0, RADIUS_HI);
            else
                rad = $urandom_range(s_min / 2, 3 * s_max);
            load_sphere(lattice_center(anchor_x[pick], grid_x, grid_x / div),
                        lattice_center(anchor_y[pick], grid_y, grid_y / div),
                        lattice_center(anchor_z[pick], grid_z, grid_z / div), rad);
        end
        repeat (nquery)
        begin
            pick = $urandom_range(0, used - 1);
            if ($urandom_range(0, 1) == 0)
                query_site(anchor_x[pick], anchor_y[pick], anchor_z[pick]);
            else
                query_site(clamp_site(anchor_x[pick] + int'($urandom_range(0, 4)) - 2),
                           clamp_site(anchor_y[pick] + int'($urandom_range(0, 4)) - 2),
                           clamp_site(anchor_z[pick] + int'($urandom_range(0, 4)) - 2));
        end
    endtask

    initial
    begin
        int target;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        mode     = MODE_CLEAR;
        center_x = '0;
        center_y = '0;
        center_z = '0;
        radius   = '0;
        site_jx  = '0;
        site_jy  = '0;
        site_jz  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values of the spacing registers.
        cfg_access(REG_SPACING_X, 1'b0, 0);
        cfg_access(REG_SPACING_Y, 1'b0, 0);
        cfg_access(REG_SPACING_Z, 1'b0, 0);

        // Directed checks at unit spacing.
        query_site(0, 0, 0);
        send_item(MODE_UNUSED, -1, -1, -1, -1, -1, -1, -1);
        load_sphere(0, 0, 0, ONE);
        query_site(0, 0, 0);
        query_site(1, 0, 0);
        query_site(0, 0, -1);
        load_sphere(ONE / 2, 0, 0, ONE);
        query_site(0, 0, 0);
        query_site(1, 0, 0);
        load_sphere(CENTER_HI, CENTER_HI, CENTER_HI, RADIUS_HI);
        load_sphere(CENTER_LO, CENTER_LO, CENTER_LO, RADIUS_HI);
        load_sphere(0, 0, 0, 0);
        load_sphere(longint'(SITE_HI) * ONE, longint'(SITE_HI) * ONE,
                    longint'(SITE_HI) * ONE, ONE);
        query_site(SITE_HI, SITE_HI, SITE_HI);
        query_site(SITE_LO, SITE_LO, SITE_LO);
        query_site(-1, 0, 0);
        clear_table();
        query_site(0, 0, 0);
        load_sphere(0, 0, 0, 1);
        query_site(0, 0, 0);
        query_site(0, 0, 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_grid(SPACING_HI, SPACING_HI, SPACING_HI);
                1: set_grid(1, 1, 1);
                2: set_grid(1, SPACING_HI, ONE);
                default: set_grid($urandom_range(1, SPACING_HI), $urandom_range(1, SPACING_HI),
                                  $urandom_range(1, SPACING_HI));
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                run_sequence();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
